@@ rtl/core/ssdp_pkg.sv @@
package ssdp_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned RowCfgW = 10;
	localparam int unsigned DivW    = 8;
	localparam int unsigned MagW    = 16;
	localparam int unsigned ValW    = 17;
	localparam int unsigned RowW    = 18;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 10;
	localparam int unsigned StepW   = $clog2(MagW);

	localparam logic [RowCfgW-1:0] CenterRowRst = RowCfgW'(250);
	localparam logic [RowCfgW-1:0] BottomRowRst = RowCfgW'(499);
	localparam logic [RowCfgW-1:0] WrapColRst   = RowCfgW'(580);
	localparam logic [DivW-1:0]    ScaleDivRst  = DivW'(20);

	localparam logic [ByteW-1:0] HdrPos = 8'hFF;
	localparam logic [ByteW-1:0] HdrNeg = 8'hFE;

	localparam logic [CfgIdxW-1:0] CfgCenterRow = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgBottomRow = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgWrapCol   = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgScaleDiv  = 2'd3;

	typedef enum logic [2:0] {
		FS_HUNT   = 3'd0,
		FS_FF1    = 3'd1,
		FS_HI_POS = 3'd2,
		FS_LO_POS = 3'd3,
		FS_FE1    = 3'd4,
		FS_HI_NEG = 3'd5,
		FS_LO_NEG = 3'd6
	} frame_state_t;

	typedef struct packed {
		logic capture_hi;
		logic frame_done;
		logic frame_neg;
	} frame_ctl_t;

endpackage

@@ rtl/core/signed_sample_deframer_plotter.sv @@
// After the transfer of a frame's last byte, the bit-serial divider is loaded
// with the magnitude; once it finishes, the result is posted and out_valid rises.
// Flow: header and high bytes are accepted without a stall; the last byte of a
// frame holds the input stalled until its result is posted, longer while a result waits.
// Reset: arst_n clears the deframer, sweep column, last row and
// configuration registers to their defaults at once; no clearing pass.
module signed_sample_deframer_plotter
	import ssdp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgW-1:0]        cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [ByteW-1:0]       rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [ValW-1:0] sample_value,
	output logic [RowCfgW-1:0]     column,
	output logic signed [RowW-1:0] row_start,
	output logic signed [RowW-1:0] row_end,
	output logic                   draw_segment,
	output logic                   clear_screen
);

	logic [RowCfgW-1:0] center_q, bottom_q, wrap_q;
	logic [DivW-1:0]    scale_q;

	frame_state_t state_q, state_d;
	frame_ctl_t   fctl;

	logic [ByteW-1:0]       high_q;
	logic [RowCfgW-1:0]     sweep_q;
	logic signed [RowW-1:0] last_row_q;
	logic                   busy_q;
	logic                   neg_q;
	logic [MagW-1:0]        mag_q;
	logic                   out_valid_q;

	logic            in_xfer;
	logic            div_start;
	logic            div_busy;
	logic [MagW-1:0] quo;
	logic            post;

	logic signed [RowW-1:0] center_ext, quo_ext, row_raw, row_fin, start_row;
	logic                   draw;
	logic                   clamp;
	logic [RowCfgW:0]       next_col;
	logic                   wrap;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CenterRowRst;
			bottom_q <= BottomRowRst;
			wrap_q   <= WrapColRst;
			scale_q  <= ScaleDivRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgCenterRow: center_q <= cfg_data[RowCfgW-1:0];
				CfgBottomRow: bottom_q <= cfg_data[RowCfgW-1:0];
				CfgWrapCol:   wrap_q   <= cfg_data[RowCfgW-1:0];
				CfgScaleDiv:  scale_q  <= cfg_data[DivW-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !busy_q;

	// deframer next state
	always_comb begin
		state_d = state_q;
		if (in_xfer) begin
			unique case (state_q)
				FS_FF1:    state_d = (rx_byte == HdrPos) ? FS_HI_POS : FS_HUNT;
				FS_HI_POS: state_d = FS_LO_POS;
				FS_LO_POS: state_d = FS_HUNT;
				FS_FE1:    state_d = (rx_byte == HdrNeg) ? FS_HI_NEG : FS_HUNT;
				FS_HI_NEG: state_d = FS_LO_NEG;
				FS_LO_NEG: state_d = FS_HUNT;
				default: begin
					priority if (rx_byte == HdrPos) state_d = FS_FF1;
					else if (rx_byte == HdrNeg) state_d = FS_FE1;
					else state_d = FS_HUNT;
				end
			endcase
		end
	end

	// deframer outputs
	always_comb begin
		fctl = '0;
		unique case (state_q)
			FS_HI_POS, FS_HI_NEG: fctl.capture_hi = 1'b1;
			FS_LO_POS:            fctl.frame_done = 1'b1;
			FS_LO_NEG: begin
				fctl.frame_done = 1'b1;
				fctl.frame_neg  = 1'b1;
			end
			default: ;
		endcase
	end

	assign div_start = in_xfer && fctl.frame_done;

	ssdp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({high_q, rx_byte}),
		.divisor  (scale_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// post once the quotient is ready and the output register is free
	assign post = busy_q && !div_busy && (!out_valid_q || !out_stall);

	assign center_ext = $signed({{(RowW-RowCfgW){1'b0}}, center_q});
	assign quo_ext    = $signed({{(RowW-MagW){1'b0}}, quo});
	assign row_raw    = neg_q ? (center_ext + quo_ext) : (center_ext - quo_ext);
	assign draw       = (sweep_q != '0);
	assign clamp      = neg_q ? (row_raw > $signed({{(RowW-RowCfgW){1'b0}}, bottom_q}))
	                          : (row_raw < $signed(RowW'(1)));
	assign row_fin    = (draw && clamp) ? last_row_q : row_raw;
	assign start_row  = draw ? last_row_q : row_raw;
	assign next_col   = {1'b0, sweep_q} + (RowCfgW+1)'(1);
	assign wrap       = next_col > {1'b0, wrap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_HUNT;
			high_q      <= '0;
			sweep_q     <= '0;
			last_row_q  <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && fctl.capture_hi) begin
				high_q <= rx_byte;
			end
			if (div_start) begin
				busy_q <= 1'b1;
			end else if (post) begin
				busy_q <= 1'b0;
			end
			if (post) begin
				out_valid_q <= 1'b1;
				last_row_q  <= row_fin;
				sweep_q     <= wrap ? '0 : next_col[RowCfgW-1:0];
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			mag_q <= {high_q, rx_byte};
			neg_q <= fctl.frame_neg;
		end
		if (post) begin
			sample_value <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
			column       <= sweep_q;
			row_start    <= start_row;
			row_end      <= row_fin;
			draw_segment <= draw;
			clear_screen <= wrap;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/ssdp_div.sv @@
module ssdp_div
	import ssdp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MagW-1:0] dividend,
	input  logic [DivW-1:0] divisor,
	output logic            busy,
	output logic [MagW-1:0] quotient
);

	logic             busy_q;
	logic [StepW-1:0] cnt_q;
	logic [MagW-1:0]  quo_q;
	logic [DivW-1:0]  rem_q;
	logic [DivW-1:0]  div_q;
	logic [DivW:0]    trial;
	logic [DivW:0]    diff;
	logic             ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[MagW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= StepW'(MagW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - StepW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			// a zero divisor acts as one
			div_q <= (divisor == '0) ? DivW'(1) : divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MagW-2:0], ge};
			rem_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
